// ===== hdl/spimbe_pkg.sv =====
`timescale 1ns / 1ps

package spimbe_pkg;

    localparam int FRAME_BITS_DEF = 8;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_STATUS = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        FLAG_EMPTY   = 2'd0,
        FLAG_DONE    = 2'd1,
        FLAG_OVERRUN = 2'd2
    } t_flag;

    typedef enum logic {
        KIND_PINS  = 1'b0,
        KIND_REPLY = 1'b1
    } t_kind;

    typedef struct packed {
        logic load;
        logic adv;
    } t_seq_ctl;

    typedef struct packed {
        t_kind       kind;
        logic        sel_n;
        logic        sclk;
        logic        mosi;
        logic [7:0]  rdata;
        logic [1:0]  status;
        logic        err;
        logic        last;
    } t_result;

endpackage

// ===== hdl/spi_master_byte_exchange.sv =====
`timescale 1ns / 1ps

// spi master, at most one frame per host access, lsb first, mode 0, select active low
// input stream: one transfer per access; tuser carries the command
//   (write, read, read status), tdata the transmit byte and the miso levels
// output stream: a run of pin-state transfers followed by one reply transfer,
//   tuser tells them apart and tlast marks the reply
// an exchange gives 2*FRAME_BITS+3 transfers (19 at 8 bits), set by the step counter,
//   one per cycle unless stalled; an access without exchange gives one transfer
// the first transfer comes from the command register loaded by the input transfer,
//   through the result register; the next access is taken in the cycle that the
//   current reply is formed, so accesses run back to back with no gap on the output
// reset deselects the slave, drives sclk and mosi low, clears the receive
//   byte and empties the receive flag
// a stall on the output holds the result register and freezes the sequence;
//   input is not taken while an access is still running

module spi_master_byte_exchange #(
    parameter int FRAME_BITS = spimbe_pkg::FRAME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // write_byte, miso_bits
    input  logic [1:0]  i_s_axis_tuser,   // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // select_n, sclk_level, mosi_level,
                                          // read_data, rx_status, read_error, zero pad
    output logic [0:0]  o_m_axis_tuser,   // result_kind
    output logic        o_m_axis_tlast    // last
);
    import spimbe_pkg::*;

    logic     r_busy;
    logic     r_out_vld;
    t_result  r_out;
    t_result  res;
    t_seq_ctl ctl;
    logic     accept;

    assign ctl.adv  = r_busy && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_busy || (ctl.adv && res.last);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign ctl.load = accept;

    spimbe_seq #(
        .FRAME_BITS(FRAME_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_cmd        (i_s_axis_tuser),
        .i_write_byte (i_s_axis_tdata[7:0]),
        .i_miso_bits  (i_s_axis_tdata[15:8]),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (ctl.adv && res.last) begin
                r_busy <= 1'b0;
            end
            if (ctl.adv) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out.err, r_out.status, r_out.rdata,
                              r_out.mosi, r_out.sclk, r_out.sel_n};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

endmodule

// ===== hdl/spimbe_seq.sv =====
`timescale 1ns / 1ps

module spimbe_seq #(
    parameter int FRAME_BITS = spimbe_pkg::FRAME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spimbe_pkg::t_seq_ctl i_ctl,
    input  logic [1:0]          i_cmd,
    input  logic [7:0]          i_write_byte,
    input  logic [7:0]          i_miso_bits,
    output spimbe_pkg::t_result o_res
);
    import spimbe_pkg::*;

    localparam int STEPS    = 2 * FRAME_BITS + 3;
    localparam int STEP_W   = $clog2(STEPS);
    localparam int RX_W     = (FRAME_BITS > 8) ? FRAME_BITS : 8;
    localparam logic [STEP_W-1:0] STEP_DESEL = STEP_W'(2 * FRAME_BITS + 1);
    localparam logic [STEP_W-1:0] STEP_REPLY = STEP_W'(2 * FRAME_BITS + 2);

    logic                  r_sel_n, n_sel_n;
    logic                  r_sclk, n_sclk;
    logic                  r_mosi, n_mosi;
    logic [FRAME_BITS-1:0] r_rx, n_rx;
    logic [1:0]            r_flag, n_flag;
    logic [STEP_W-1:0]     r_step;
    logic [1:0]            r_cmd;
    logic [7:0]            r_tx, n_tx;
    logic [7:0]            r_miso, n_miso;

    logic                  exch;
    logic [FRAME_BITS:0]   rx_shift;
    logic [RX_W-1:0]       rx_ext;
    logic                  is_reply;

    assign exch = (r_cmd == CMD_WRITE) || (r_cmd == CMD_READ && r_flag == FLAG_EMPTY);
    assign rx_shift = {r_miso[0], r_rx};
    assign rx_ext   = RX_W'(r_rx);
    assign is_reply = exch ? (r_step == STEP_REPLY) : 1'b1;

    always_comb begin
        n_sel_n = r_sel_n;
        n_sclk  = r_sclk;
        n_mosi  = r_mosi;
        n_rx    = r_rx;
        n_flag  = r_flag;
        n_tx    = r_tx;
        n_miso  = r_miso;
        o_res   = '0;
        if (is_reply) begin
            o_res.kind = KIND_REPLY;
            o_res.last = 1'b1;
            unique case (r_cmd)
                CMD_WRITE: begin
                    n_flag = (r_flag != FLAG_EMPTY) ? FLAG_OVERRUN : FLAG_DONE;
                    o_res.status = n_flag;
                end
                CMD_READ: begin
                    if (r_flag == FLAG_OVERRUN) begin
                        o_res.err    = 1'b1;
                        o_res.status = r_flag;
                    end else begin
                        o_res.rdata  = rx_ext[7:0];
                        n_rx         = '0;
                        n_flag       = FLAG_EMPTY;
                        o_res.status = FLAG_EMPTY;
                    end
                end
                default: begin
                    o_res.status = r_flag;
                end
            endcase
        end else if (r_step == '0) begin
            n_sel_n = 1'b0;
        end else if (r_step == STEP_DESEL) begin
            n_sel_n = 1'b1;
        end else if (r_step[0]) begin
            // clock low, next data bit out
            n_sclk = 1'b0;
            n_mosi = (r_cmd == CMD_WRITE) & r_tx[0];
        end else begin
            // clock high, sample miso
            n_sclk = 1'b1;
            n_rx   = rx_shift[FRAME_BITS:1];
            n_tx   = r_tx >> 1;
            n_miso = r_miso >> 1;
        end
        o_res.sel_n = n_sel_n;
        o_res.sclk  = n_sclk;
        o_res.mosi  = n_mosi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_n <= 1'b1;
            r_sclk  <= 1'b0;
            r_mosi  <= 1'b0;
            r_rx    <= '0;
            r_flag  <= FLAG_EMPTY;
            r_step  <= '0;
        end else if (i_ctl.adv) begin
            r_sel_n <= n_sel_n;
            r_sclk  <= n_sclk;
            r_mosi  <= n_mosi;
            r_rx    <= n_rx;
            r_flag  <= n_flag;
            r_step  <= is_reply ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_tx   <= i_write_byte;
            r_miso <= i_miso_bits;
        end else if (i_ctl.adv) begin
            r_tx   <= n_tx;
            r_miso <= n_miso;
        end
    end

    a_pins_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.adv && o_res.kind == KIND_PINS |->
            o_res.rdata == 8'd0 && o_res.status == 2'd0 && !o_res.err && !o_res.last)
        else $error("pin result carries reply fields");

    a_err_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.adv && o_res.err |-> r_flag == FLAG_OVERRUN)
        else $error("read refused without overrun");

    a_step_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.adv && o_res.last |=> r_step == '0)
        else $error("step counter not rewound after reply");

    a_reply_desel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.adv && o_res.kind == KIND_REPLY |-> o_res.sel_n)
        else $error("reply while slave still selected");

endmodule
